// ----- hdl/htb_pkg.sv -----
// Shared types for the Huffman tree builder.
package htb_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PUSH_CMP,
    ST_BUILD,
    ST_POP,
    ST_POP_TAKE,
    ST_SD_RD,
    ST_SD_CMPL,
    ST_SD_CMPR,
    ST_MERGE,
    ST_ROOT,
    ST_ROOT_TAKE,
    ST_NODE_RD,
    ST_NODE_ACT,
    ST_STK_TAKE
  } state_t;

endpackage

// ----- hdl/htb_alu.sv -----
// Shared weight comparator and adder used by the heap compare and merge steps.
module htb_alu #(
  parameter int W = 30
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic [W-1:0] sum
);
  import htb_pkg::*;

  assign lt  = a < b;
  assign sum = a + b;

endmodule

// ----- hdl/htb_heap_mem.sv -----
// Heap slot memory: one write port, two registered read ports.
module htb_heap_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 37
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);
  import htb_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/huffman_tree_builder.sv -----
// Huffman tree builder top level: sequencer, node store and walk stack.
// Load: each item is written to the node store and sifted up the heap, one level per compare.
// Build: repeated pops and pushes through one comparator/adder merge the two lightest nodes,
// then the tree is walked from the root, left subtree first, emitting leaves; out_stall holds the walk.
// in_stall: high after an accepted item until its push (last item: build and walk) is done.
// rst_n synchronously clears counts, flags and the sequencer; stores are not cleared.
module huffman_tree_builder #(
  parameter int MAX_SYMBOLS = 64,
  parameter int WEIGHT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol_in,
  input  logic [23:0] in_weight_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol_out,
  output logic       out_last_out,
  output logic       out_overflowed
);
  import htb_pkg::*;

  localparam int HW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int NDEPTH = 2 * MAX_SYMBOLS - 1;
  localparam int NW = $clog2(NDEPTH);
  localparam int SW = WEIGHT_BITS + HW;
  localparam int EW = SW + NW;
  localparam int MW = 8 + 2 * NW;
  localparam int LW = HW + 2;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, loaded_r, loaded_nxt;
  logic          drop_r, drop_nxt, last_r, last_nxt, pop2_r, pop2_nxt;
  logic [HW-1:0] i_r, i_nxt;
  logic [EW-1:0] item_r, item_nxt, top_r, top_nxt, a_r, a_nxt;
  logic [SW-1:0] min_r, min_nxt;
  logic          sel_l_r, sel_l_nxt;
  logic [NW-1:0] next_r, next_nxt, cur_r, cur_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt, out_ovf_r, out_ovf_nxt;
  logic [7:0]    out_sym_r, out_sym_nxt;

  // heap memory
  logic          hm_we, hm_re;
  logic [HW-1:0] hm_waddr, hm_raddr_a, hm_raddr_b;
  logic [EW-1:0] hm_wdata, hm_rdata_a, hm_rdata_b;

  // node store {symbol, left, right} and walk stack
  logic [MW-1:0] node_mem [NDEPTH];
  logic          nm_we;
  logic [NW-1:0] nm_waddr;
  logic [MW-1:0] nm_wdata, nm_rdata;
  logic [NW-1:0] stk_mem [MAX_SYMBOLS];
  logic          stk_we, stk_re;
  logic [HW-1:0] stk_waddr, stk_raddr;
  logic [NW-1:0] stk_wdata, stk_rdata;

  logic [SW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_lt;

  logic [SW-1:0] w_in;
  logic [LW-1:0] l_w, r_w, cnt_w;
  logic [HW-1:0] parent;
  logic          accept, emit_ok, is_leaf;

  htb_heap_mem #(.DEPTH(MAX_SYMBOLS), .AW(HW), .DW(EW)) u_heap (
    .clk     (clk),
    .we      (hm_we),
    .waddr   (hm_waddr),
    .wdata   (hm_wdata),
    .re      (hm_re),
    .raddr_a (hm_raddr_a),
    .raddr_b (hm_raddr_b),
    .rdata_a (hm_rdata_a),
    .rdata_b (hm_rdata_b)
  );

  htb_alu #(.W(SW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .lt  (alu_lt),
    .sum (alu_sum)
  );

  always_ff @(posedge clk) begin
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    nm_rdata <= node_mem[cur_r];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  assign w_in    = SW'(in_weight_in) & ((SW'(1) << WEIGHT_BITS) - SW'(1));
  assign l_w     = LW'({i_r, 1'b1});
  assign r_w     = l_w + LW'(1);
  assign cnt_w   = LW'(cnt_r);
  assign parent  = HW'((i_r - HW'(1)) >> 1);
  assign accept  = in_valid && !in_stall;
  assign emit_ok = !out_valid_r || !out_stall;
  assign is_leaf = cur_r < NW'(loaded_r);

  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_symbol_out = out_sym_r;
  assign out_last_out   = out_last_r;
  assign out_overflowed = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    loaded_nxt    = loaded_r;
    drop_nxt      = drop_r;
    last_nxt      = last_r;
    pop2_nxt      = pop2_r;
    i_nxt         = i_r;
    item_nxt      = item_r;
    top_nxt       = top_r;
    a_nxt         = a_r;
    min_nxt       = min_r;
    sel_l_nxt     = sel_l_r;
    next_nxt      = next_r;
    cur_nxt       = cur_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    hm_we         = 1'b0;
    hm_waddr      = i_r;
    hm_wdata      = item_r;
    hm_re         = 1'b0;
    hm_raddr_a    = '0;
    hm_raddr_b    = '0;
    nm_we         = 1'b0;
    nm_waddr      = next_r;
    nm_wdata      = '0;
    stk_we        = 1'b0;
    stk_waddr     = HW'(sp_r);
    stk_wdata     = nm_rdata[NW-1:0];
    stk_re        = 1'b0;
    stk_raddr     = HW'(sp_r - CW'(1));
    alu_a         = item_r[EW-1:NW];
    alu_b         = hm_rdata_a[EW-1:NW];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_last_in;
          if (loaded_r < CW'(MAX_SYMBOLS)) begin
            nm_we      = 1'b1;
            nm_waddr   = NW'(loaded_r);
            nm_wdata   = {in_symbol_in, {(2 * NW){1'b0}}};
            item_nxt   = {w_in, NW'(loaded_r)};
            i_nxt      = HW'(cnt_r);
            cnt_nxt    = cnt_r + CW'(1);
            loaded_nxt = loaded_r + CW'(1);
            state_nxt  = ST_PUSH;
          end else begin
            drop_nxt  = 1'b1;
            state_nxt = in_last_in ? ST_BUILD : ST_IDLE;
          end
          next_nxt = NW'(loaded_nxt);
        end
      end
      ST_PUSH: begin
        if (i_r == '0) begin
          hm_we     = 1'b1;
          state_nxt = last_r ? ST_BUILD : ST_IDLE;
        end else begin
          hm_re      = 1'b1;
          hm_raddr_a = parent;
          state_nxt  = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        // sift-up: item climbs only past strictly heavier parents
        if (alu_lt) begin
          hm_we     = 1'b1;
          hm_wdata  = hm_rdata_a;
          i_nxt     = parent;
          state_nxt = ST_PUSH;
        end else begin
          hm_we     = 1'b1;
          state_nxt = last_r ? ST_BUILD : ST_IDLE;
        end
      end
      ST_BUILD: begin
        pop2_nxt  = 1'b0;
        state_nxt = (cnt_r > CW'(1)) ? ST_POP : ST_ROOT;
      end
      ST_POP: begin
        hm_re      = 1'b1;
        hm_raddr_a = '0;
        hm_raddr_b = HW'(cnt_r - CW'(1));
        state_nxt  = ST_POP_TAKE;
      end
      ST_POP_TAKE: begin
        top_nxt   = hm_rdata_a;
        item_nxt  = hm_rdata_b;
        cnt_nxt   = cnt_r - CW'(1);
        i_nxt     = '0;
        state_nxt = ST_SD_RD;
      end
      ST_SD_RD: begin
        if (l_w < cnt_w) begin
          hm_re      = 1'b1;
          hm_raddr_a = HW'(l_w);
          hm_raddr_b = HW'(r_w);
          state_nxt  = ST_SD_CMPL;
        end else begin
          hm_we = 1'b1;
          if (pop2_r) begin
            state_nxt = ST_MERGE;
          end else begin
            a_nxt     = top_r;
            pop2_nxt  = 1'b1;
            state_nxt = ST_POP;
          end
        end
      end
      ST_SD_CMPL: begin
        alu_a     = hm_rdata_a[EW-1:NW];
        alu_b     = item_r[EW-1:NW];
        sel_l_nxt = alu_lt;
        min_nxt   = alu_lt ? hm_rdata_a[EW-1:NW] : item_r[EW-1:NW];
        state_nxt = ST_SD_CMPR;
      end
      ST_SD_CMPR: begin
        alu_a = hm_rdata_b[EW-1:NW];
        alu_b = min_r;
        hm_we = 1'b1;
        priority if ((r_w < cnt_w) && alu_lt) begin
          hm_wdata  = hm_rdata_b;
          i_nxt     = HW'(r_w);
          state_nxt = ST_SD_RD;
        end else if (sel_l_r) begin
          hm_wdata  = hm_rdata_a;
          i_nxt     = HW'(l_w);
          state_nxt = ST_SD_RD;
        end else begin
          if (pop2_r) begin
            state_nxt = ST_MERGE;
          end else begin
            a_nxt     = top_r;
            pop2_nxt  = 1'b1;
            state_nxt = ST_POP;
          end
        end
      end
      ST_MERGE: begin
        alu_a     = a_r[EW-1:NW];
        alu_b     = top_r[EW-1:NW];
        nm_we     = 1'b1;
        nm_wdata  = {8'h00, a_r[NW-1:0], top_r[NW-1:0]};
        item_nxt  = {alu_sum, next_r};
        i_nxt     = HW'(cnt_r);
        cnt_nxt   = cnt_r + CW'(1);
        next_nxt  = next_r + NW'(1);
        pop2_nxt  = 1'b0;
        state_nxt = ST_PUSH;
      end
      ST_ROOT: begin
        hm_re      = 1'b1;
        hm_raddr_a = '0;
        sp_nxt     = '0;
        state_nxt  = ST_ROOT_TAKE;
      end
      ST_ROOT_TAKE: begin
        cur_nxt   = hm_rdata_a[NW-1:0];
        state_nxt = ST_NODE_RD;
      end
      ST_NODE_RD: begin
        state_nxt = ST_NODE_ACT;
      end
      ST_NODE_ACT: begin
        if (is_leaf) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_sym_nxt   = nm_rdata[MW-1:2*NW];
            out_last_nxt  = sp_r == '0;
            out_ovf_nxt   = drop_r;
            if (sp_r == '0) begin
              cnt_nxt    = '0;
              loaded_nxt = '0;
              drop_nxt   = 1'b0;
              last_nxt   = 1'b0;
              state_nxt  = ST_IDLE;
            end else begin
              stk_re    = 1'b1;
              sp_nxt    = sp_r - CW'(1);
              state_nxt = ST_STK_TAKE;
            end
          end
        end else begin
          // left subtree first; right child waits on the stack
          stk_we    = 1'b1;
          sp_nxt    = sp_r + CW'(1);
          cur_nxt   = nm_rdata[2*NW-1:NW];
          state_nxt = ST_NODE_RD;
        end
      end
      ST_STK_TAKE: begin
        cur_nxt   = stk_rdata;
        state_nxt = ST_NODE_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      loaded_r    <= '0;
      drop_r      <= 1'b0;
      last_r      <= 1'b0;
      pop2_r      <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      loaded_r    <= loaded_nxt;
      drop_r      <= drop_nxt;
      last_r      <= last_nxt;
      pop2_r      <= pop2_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    item_r     <= item_nxt;
    top_r      <= top_nxt;
    a_r        <= a_nxt;
    min_r      <= min_nxt;
    sel_l_r    <= sel_l_nxt;
    next_r     <= next_nxt;
    cur_r      <= cur_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SYMBOLS))
    else $error("heap count above capacity");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= CW'(MAX_SYMBOLS))
    else $error("loaded count above capacity");

  a_idle_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == loaded_r))
    else $error("heap does not hold every loaded leaf between items");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r < CW'(MAX_SYMBOLS))
    else $error("walk stack overflow");

endmodule

// ----- tb/sv/tb_huffman_tree_builder.sv -----
// Testbench for the Huffman tree builder: random sets, in-order leaf checks.
module tb_huffman_tree_builder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SYM = 64;

  typedef struct {
    logic [7:0] symbol;
    logic       last;
    logic       ovf;
  } leaf_t;

  int err_count = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Tree predictor and queue of expected leaves
  class leaf_scoreboard;
    logic [29:0] wgt [127];
    logic [7:0]  sym [127];
    bit          is_leaf [127];
    logic [6:0]  lch [127];
    logic [6:0]  rch [127];
    logic [6:0]  heap [64];
    int          heap_n;
    int          loaded;
    bit          dropped;
    leaf_t       pending[$];

    function void push(logic [6:0] nd);
      int i;
      i = heap_n++;
      while (i > 0 && wgt[nd] < wgt[heap[(i - 1) / 2]]) begin
        heap[i] = heap[(i - 1) / 2];
        i = (i - 1) / 2;
      end
      heap[i] = nd;
    endfunction

    function logic [6:0] pop();
      logic [6:0] top, t;
      int i, s, l, r;
      top = heap[0];
      heap[0] = heap[heap_n - 1];
      heap_n--;
      i = 0;
      forever begin
        s = i; l = 2 * i + 1; r = 2 * i + 2;
        if (l < heap_n && wgt[heap[l]] < wgt[heap[s]]) s = l;
        if (r < heap_n && wgt[heap[r]] < wgt[heap[s]]) s = r;
        if (s == i) break;
        t = heap[s]; heap[s] = heap[i]; heap[i] = t;
        i = s;
      end
      return top;
    endfunction

    function void note_item(logic [7:0] s, logic [23:0] w, logic last);
      int nxt;
      logic [6:0] a, b, nd;
      logic [6:0] stk[$];
      leaf_t lf;
      if (loaded < MAX_SYM) begin
        wgt[loaded] = {6'd0, w};
        sym[loaded] = s;
        is_leaf[loaded] = 1;
        push(loaded[6:0]);
        loaded++;
      end else
        dropped = 1;
      if (!last) return;
      nxt = loaded;
      while (heap_n > 1) begin
        a = pop();
        b = pop();
        wgt[nxt] = wgt[a] + wgt[b];
        is_leaf[nxt] = 0;
        lch[nxt] = a;
        rch[nxt] = b;
        push(nxt[6:0]);
        nxt++;
      end
      stk.push_back(heap[0]);
      while (stk.size() > 0) begin
        nd = stk.pop_back();
        if (is_leaf[nd]) begin
          lf.symbol = sym[nd];
          lf.last = 0;
          lf.ovf = dropped;
          pending.push_back(lf);
        end else begin
          stk.push_back(rch[nd]);
          stk.push_back(lch[nd]);
        end
      end
      pending[pending.size() - 1].last = 1;
      heap_n = 0;
      loaded = 0;
      dropped = 0;
    endfunction

    task check_leaf(logic [7:0] s, logic l, logic o);
      leaf_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected leaf sym=%0d", s));
        return;
      end
      e = pending.pop_front();
      if (s !== e.symbol) report($sformatf("symbol %0d, want %0d", s, e.symbol));
      if (l !== e.last) report($sformatf("last_out %0b, want %0b", l, e.last));
      if (o !== e.ovf) report($sformatf("overflowed %0b, want %0b", o, e.ovf));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] in_symbol_in = '0;
  logic [23:0] in_weight_in = '0;
  logic in_last_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_symbol_out;
  logic out_last_out;
  logic out_overflowed;

  leaf_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;

  always #5 clk = ~clk;

  huffman_tree_builder i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_symbol_in(in_symbol_in), .in_weight_in(in_weight_in), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_symbol_out(out_symbol_out), .out_last_out(out_last_out),
    .out_overflowed(out_overflowed)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_leaf(out_symbol_out, out_last_out, out_overflowed);
  end

  // Receiver stall pattern: alternates among none, light, heavy
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Drive one item; valid drops only for a random gap between bursts
  task automatic send_item(input logic [7:0] s, input logic [23:0] w, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_symbol_in <= s;
    in_weight_in <= w;
    in_last_in <= last;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_item(s, w, last);
    @(negedge clk);
  endtask

  task automatic send_set(input int n, input int wmode);
    logic [23:0] w;
    for (int i = 0; i < n; i++) begin
      case (wmode)
        0: w = $urandom;
        1: w = $urandom_range(0, 7);
        2: w = 24'hFFFFFF;
        default: w = 5;
      endcase
      send_item($urandom, w, i == n - 1);
    end
  endtask

  initial begin
    int sent;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: single leaf, extremes, ties, full set with overflow
    send_item(8'h00, 24'h000000, 1);
    send_item(8'hFF, 24'hFFFFFF, 1);
    send_item(8'h00, 24'h000000, 0);
    send_item(8'hFF, 24'hFFFFFF, 1);
    send_set(3, 3);
    send_set(4, 2);
    send_set(5, 1);
    send_set(MAX_SYM + 2, 2);
    sent = 0;
    while (sent < 20) begin
      int n;
      n = $urandom_range(1, 8);
      send_set(n, $urandom_range(0, 3));
      sent += n;
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/htb_pkg.sv
hdl/htb_alu.sv
hdl/htb_heap_mem.sv
hdl/huffman_tree_builder.sv
tb/sv/tb_huffman_tree_builder.sv
